// ===== rtl/record_frame_byte_stuffer_top_macros.svh =====
// Assertion macros for the record frame byte stuffer.
// Included by RTL files that carry concurrent checks; needs no other file.
`ifndef RECORD_FRAME_BYTE_STUFFER_TOP_MACROS_SVH
`define RECORD_FRAME_BYTE_STUFFER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define RFBS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define RFBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFBS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/rfbs_pkg.sv =====
// Shared types and constants of the record frame byte stuffer.
// No dependencies; every other RTL file except the macro header uses it.
package rfbs_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] word_t;

	localparam int RFBS_LANES = 7;

	localparam byte_t FLAG_BYTE = 8'h7E;
	localparam byte_t ESC_BYTE  = 8'h7D;
	localparam byte_t ESC_XOR   = 8'h20;

	// Serializer position: opening flag, one slot per lane, closing flag.
	typedef logic [3:0] pos_t;
	typedef logic [2:0] lane_idx_t;

	localparam pos_t POS_OPEN = 4'd0;
	localparam pos_t POS_LAST = 4'(RFBS_LANES + 1);

	// What one lane found for its payload byte.
	typedef struct packed {
		logic  esc;
		byte_t first;
		byte_t second;
	} lane_res_t;

endpackage

// ===== rtl/rfbs_rec_if.sv =====
// Record channel: valid/ready handshake carrying one command record.
// Depends on rfbs_pkg.
interface rfbs_rec_if;
	logic                   valid;
	logic                   ready;
	rfbs_pkg::word_t        trans_id;
	rfbs_pkg::byte_t        op_code;
	rfbs_pkg::word_t        target_addr;
	logic signed [15:0]     payload;

	modport source (output valid, trans_id, op_code, target_addr, payload, input ready);
	modport sink   (input valid, trans_id, op_code, target_addr, payload, output ready);
endinterface

// ===== rtl/rfbs_byte_if.sv =====
// Byte channel: valid/ready handshake carrying one frame byte and its end mark.
// Depends on rfbs_pkg.
interface rfbs_byte_if;
	logic            valid;
	logic            ready;
	rfbs_pkg::byte_t out_byte;
	logic            frame_end;

	modport source (output valid, out_byte, frame_end, input ready);
	modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

// ===== rtl/record_frame_byte_stuffer_top.sv =====
// Channel   Dir  Handshake      Payload
// rec       in   valid/ready    trans_id, op_code, target_addr, payload
// frame     out  valid/ready    out_byte, frame_end
//
// A record turns into 9 to 16 frame bytes, one byte per cycle on frame while
// frame is ready, so the merge serializer sets the sustained input rate. Seven
// lanes classify the payload bytes in the cycle a record is accepted. The
// opening flag is offered once the record has passed the holding stage
// (valid_s1) and the merge stage has taken it (busy_q). Reset clears the valid
// flags and the serializer position; the data registers keep their contents.
// Back pressure on frame holds the current byte; the holding stage takes a new
// record while a frame drains.
// Depends on rfbs_pkg, rfbs_rec_if, rfbs_byte_if, rfbs_lane and rfbs_merge.
module record_frame_byte_stuffer_top (
	input  logic       clk,
	input  logic       arst_n,
	rfbs_rec_if.sink   rec,
	rfbs_byte_if.source frame
);
	import rfbs_pkg::*;

	byte_t     body [RFBS_LANES];
	lane_res_t lane_res [RFBS_LANES];
	lane_res_t lanes_s1 [RFBS_LANES];
	logic      valid_s1;
	logic      take;
	logic      rec_fire;

	// Little-endian byte order of the record body.
	assign body[0] = rec.trans_id[7:0];
	assign body[1] = rec.trans_id[15:8];
	assign body[2] = rec.op_code;
	assign body[3] = rec.target_addr[7:0];
	assign body[4] = rec.target_addr[15:8];
	assign body[5] = rec.payload[7:0];
	assign body[6] = rec.payload[15:8];

	// One stuffing lane per payload byte.
	for (genvar g = 0; g < RFBS_LANES; g++) begin : g_lane
		rfbs_lane u_lane (
			.body (body[g]),
			.res  (lane_res[g])
		);
	end

	// Holding stage: accept when empty or when the serializer drains it now.
	assign rec.ready = !valid_s1 || take;
	assign rec_fire  = rec.valid && rec.ready;

	always_ff @(posedge clk) begin
		if (rec_fire) begin
			lanes_s1 <= lane_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rec_fire) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Merge the lane results into the outgoing byte stream.
	rfbs_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.lanes       (lanes_s1),
		.lanes_valid (valid_s1),
		.lanes_take  (take),
		.frame       (frame)
	);
endmodule

// ===== rtl/rfbs_lane.sv =====
// One stuffing lane: classifies a payload byte and prepares its wire bytes.
// Depends on rfbs_pkg.
module rfbs_lane (
	input  rfbs_pkg::byte_t   body,
	output rfbs_pkg::lane_res_t res
);
	import rfbs_pkg::*;

	logic hit;

	assign hit = (body == FLAG_BYTE) || (body == ESC_BYTE);

	always_comb begin
		res.esc    = hit;
		res.first  = hit ? ESC_BYTE : body;
		res.second = body ^ ESC_XOR;
	end
endmodule

// ===== rtl/rfbs_merge.sv =====
// Merge stage: walks the lane results of one record and sends the stuffed frame.
// Depends on rfbs_pkg, rfbs_byte_if and the assertion macro header.
`include "record_frame_byte_stuffer_top_macros.svh"
module rfbs_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  rfbs_pkg::lane_res_t lanes [rfbs_pkg::RFBS_LANES],
	input  logic                lanes_valid,
	output logic                lanes_take,
	rfbs_byte_if.source         frame
);
	import rfbs_pkg::*;

	lane_res_t lanes_q [RFBS_LANES];
	pos_t      pos_q;
	logic      half_q;
	logic      busy_q;

	lane_idx_t idx;
	lane_res_t cur;
	logic      in_body;
	logic      fire;
	logic      at_last;
	logic      last_fire;

	assign in_body   = (pos_q != POS_OPEN) && (pos_q != POS_LAST);
	assign idx       = lane_idx_t'(pos_q - 4'd1);
	assign cur       = lanes_q[in_body ? idx : '0];
	assign fire      = frame.valid && frame.ready;
	assign at_last   = (pos_q == POS_LAST);
	assign last_fire = fire && at_last;

	// Take the next record when idle or as the closing flag leaves.
	assign lanes_take = lanes_valid && (!busy_q || (fire && at_last));

	always_comb begin
		frame.valid     = busy_q;
		frame.frame_end = at_last;
		if (!in_body) begin
			frame.out_byte = FLAG_BYTE;
		end else if (half_q) begin
			frame.out_byte = cur.second;
		end else begin
			frame.out_byte = cur.first;
		end
	end

	always_ff @(posedge clk) begin
		if (lanes_take) begin
			lanes_q <= lanes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= POS_OPEN;
			half_q <= 1'b0;
		end else if (lanes_take) begin
			busy_q <= 1'b1;
			pos_q  <= POS_OPEN;
			half_q <= 1'b0;
		end else if (fire) begin
			if (at_last) begin
				busy_q <= 1'b0;
				pos_q  <= POS_OPEN;
				half_q <= 1'b0;
			end else if (in_body && cur.esc && !half_q) begin
				half_q <= 1'b1;
			end else begin
				half_q <= 1'b0;
				pos_q  <= pos_q + 4'd1;
			end
		end
	end

	`RFBS_ASSERT(a_half_in_body, clk, arst_n, half_q |-> in_body, "escape half outside payload")
	`RFBS_ASSERT(a_frame_continues, clk, arst_n, fire && !at_last |=> busy_q, "frame cut short")
	`RFBS_ASSERT(a_idle_after_end, clk, arst_n, last_fire && !lanes_valid |=> !busy_q, "busy with no record")
	`RFBS_ASSERT_ALWAYS(a_pos_bound, clk, !arst_n || pos_q <= POS_LAST, "position past closing flag")
endmodule
